>>> rtl/bgr_pkg.sv
`timescale 1ns / 1ps

package bgr_pkg;

    localparam int DEF_FONT_BYTES       = 4096;
    localparam int DEF_MAX_GLYPH_PIXELS = 63;
    localparam int QUEUE_DEPTH          = 2;

    localparam logic [31:0] FONT_MAGIC = 32'h21324642;
    localparam int          HDR_FIRST  = 4;
    localparam int          HDR_LAST   = 5;

    localparam logic [7:0] SPACE_LEN_RESET = 8'd5;

    // input kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_DRAW  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NO_CODE   = 2'd1;
    localparam logic [1:0] STAT_BAD_MAGIC = 2'd2;
    localparam logic [1:0] STAT_TRUNC     = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_DRAW_COLOR  = 3'd0;
    localparam logic [2:0] REG_CLIP_ENABLE = 3'd1;
    localparam logic [2:0] REG_CLIP_LEFT   = 3'd2;
    localparam logic [2:0] REG_CLIP_TOP    = 3'd3;
    localparam logic [2:0] REG_CLIP_RIGHT  = 3'd4;
    localparam logic [2:0] REG_CLIP_BOTTOM = 3'd5;
    localparam logic [2:0] REG_SPACE_LEN   = 3'd6;
    localparam logic [2:0] REG_FONT_SIZE   = 3'd7;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_DRAW,
        OP_QUERY
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [11:0]        addr;
        logic [7:0]         wbyte;
        logic [7:0]         code;
        logic signed [15:0] ox;
        logic signed [15:0] oy;
    } cmd_t;

    typedef struct packed {
        logic [23:0]        draw_color;
        logic               clip_enable;
        logic signed [15:0] clip_left;
        logic signed [15:0] clip_top;
        logic signed [15:0] clip_right;
        logic signed [15:0] clip_bottom;
        logic [7:0]         space_len;
        logic [12:0]        font_size;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAG0,
        ST_MAG1,
        ST_MAG2,
        ST_MAG3,
        ST_FIRST,
        ST_LAST,
        ST_TBL0,
        ST_TBL1,
        ST_WIDTH,
        ST_CNT0,
        ST_CNT1,
        ST_PIX_X,
        ST_PIX_Y,
        ST_FINAL
    } state_t;

endpackage

>>> rtl/bitmap_glyph_rasterizer_top.sv
`timescale 1ns / 1ps
// font write: passes the front register and the queue, then is written to the store when the
//   sequencer takes it in idle; a draw reads magic, header, offset table, width and count before
//   its first pixel, then one store read each for dx and dy per pixel on the single store port
// throughput: one word every cycle at the input while the queue has room; draws run one at a time
// reset: aresetn clears control state and config registers (space_len to 5), store is not cleared
module bitmap_glyph_rasterizer_top #(
    parameter int FONT_BYTES       = bgr_pkg::DEF_FONT_BYTES,
    parameter int MAX_GLYPH_PIXELS = bgr_pkg::DEF_MAX_GLYPH_PIXELS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic [11:0]        s_font_address,
    input  logic [7:0]         s_font_byte,
    input  logic [7:0]         s_char_code,
    input  logic signed [15:0] s_origin_x,
    input  logic signed [15:0] s_origin_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [16:0] m_pixel_x,
    output logic signed [16:0] m_pixel_y,
    output logic [23:0]        m_pixel_color,
    output logic [7:0]         m_advance,
    output logic [1:0]         m_status,
    output logic               m_last
);
    import bgr_pkg::*;

    cfg_t cfg_reg;
    cmd_t f_cmd;
    logic f_valid;
    logic f_ready;
    cmd_t q_cmd;
    logic q_valid;
    logic q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.draw_color  <= '0;
            cfg_reg.clip_enable <= 1'b0;
            cfg_reg.clip_left   <= '0;
            cfg_reg.clip_top    <= '0;
            cfg_reg.clip_right  <= '0;
            cfg_reg.clip_bottom <= '0;
            cfg_reg.space_len   <= SPACE_LEN_RESET;
            cfg_reg.font_size   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_DRAW_COLOR:  cfg_reg.draw_color  <= cfg_data;
                REG_CLIP_ENABLE: cfg_reg.clip_enable <= cfg_data[0];
                REG_CLIP_LEFT:   cfg_reg.clip_left   <= $signed(cfg_data[15:0]);
                REG_CLIP_TOP:    cfg_reg.clip_top    <= $signed(cfg_data[15:0]);
                REG_CLIP_RIGHT:  cfg_reg.clip_right  <= $signed(cfg_data[15:0]);
                REG_CLIP_BOTTOM: cfg_reg.clip_bottom <= $signed(cfg_data[15:0]);
                REG_SPACE_LEN:   cfg_reg.space_len   <= cfg_data[7:0];
                REG_FONT_SIZE:   cfg_reg.font_size   <= cfg_data[12:0];
                default:         cfg_reg.font_size   <= cfg_reg.font_size;
            endcase
        end
    end

    bgr_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_font_address (s_font_address),
        .s_font_byte    (s_font_byte),
        .s_char_code    (s_char_code),
        .s_origin_x     (s_origin_x),
        .s_origin_y     (s_origin_y),
        .f_cmd          (f_cmd),
        .f_valid        (f_valid),
        .f_ready        (f_ready)
    );

    bgr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_cmd    (f_cmd),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .out_cmd   (q_cmd),
        .out_valid (q_valid),
        .out_pop   (q_pop)
    );

    bgr_back #(
        .FONT_BYTES       (FONT_BYTES),
        .MAX_GLYPH_PIXELS (MAX_GLYPH_PIXELS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_cmd         (q_cmd),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .cfg           (cfg_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_color (m_pixel_color),
        .m_advance     (m_advance),
        .m_status      (m_status),
        .m_last        (m_last)
    );

endmodule

>>> rtl/bgr_front.sv
`timescale 1ns / 1ps

module bgr_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic [11:0]        s_font_address,
    input  logic [7:0]         s_font_byte,
    input  logic [7:0]         s_char_code,
    input  logic signed [15:0] s_origin_x,
    input  logic signed [15:0] s_origin_y,
    output bgr_pkg::cmd_t      f_cmd,
    output logic               f_valid,
    input  logic               f_ready
);
    import bgr_pkg::*;

    cmd_t cmd_reg;
    logic hold_valid_reg;
    logic kind_ok;
    op_t  op_dec;

    always_comb begin
        kind_ok = 1'b1;
        op_dec  = OP_WRITE;
        case (s_kind)
            KIND_WRITE: op_dec = OP_WRITE;
            KIND_DRAW:  op_dec = OP_DRAW;
            KIND_QUERY: op_dec = OP_QUERY;
            default:    kind_ok = 1'b0;   // unused kind is dropped here
        endcase
    end

    assign s_ready = !hold_valid_reg || f_ready;
    assign f_valid = hold_valid_reg;
    assign f_cmd   = cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (s_ready) begin
            hold_valid_reg <= s_valid && kind_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg.op    <= op_dec;
            cmd_reg.addr  <= s_font_address;
            cmd_reg.wbyte <= s_font_byte;
            cmd_reg.code  <= s_char_code;
            cmd_reg.ox    <= s_origin_x;
            cmd_reg.oy    <= s_origin_y;
        end
    end

endmodule

>>> rtl/bgr_queue.sv
`timescale 1ns / 1ps

module bgr_queue #(
    parameter int DEPTH = bgr_pkg::QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  bgr_pkg::cmd_t in_cmd,
    input  logic          in_valid,
    output logic          in_ready,
    output bgr_pkg::cmd_t out_cmd,
    output logic          out_valid,
    input  logic          out_pop
);
    import bgr_pkg::*;

    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    cmd_t            slot_reg [DEPTH];
    logic [PTRW-1:0] wr_ptr_reg;
    logic [PTRW-1:0] rd_ptr_reg;
    logic [CNTW-1:0] count_reg;
    logic            push;
    logic            pop;

    assign in_ready  = count_reg != CNTW'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    function automatic logic [PTRW-1:0] ptr_inc(input logic [PTRW-1:0] p);
        ptr_inc = (p == PTRW'(DEPTH - 1)) ? '0 : p + PTRW'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNTW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNTW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

>>> rtl/bgr_back.sv
`timescale 1ns / 1ps

module bgr_back #(
    parameter int FONT_BYTES       = bgr_pkg::DEF_FONT_BYTES,
    parameter int MAX_GLYPH_PIXELS = bgr_pkg::DEF_MAX_GLYPH_PIXELS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  bgr_pkg::cmd_t      q_cmd,
    input  logic               q_valid,
    output logic               q_pop,
    input  bgr_pkg::cfg_t      cfg,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [16:0] m_pixel_x,
    output logic signed [16:0] m_pixel_y,
    output logic [23:0]        m_pixel_color,
    output logic [7:0]         m_advance,
    output logic [1:0]         m_status,
    output logic               m_last
);
    import bgr_pkg::*;

    localparam int AW = $clog2(FONT_BYTES);
    localparam int PW = $clog2(MAX_GLYPH_PIXELS + 1);

    // font store
    logic [7:0]    mem [FONT_BYTES];
    logic [7:0]    rdata_reg;
    logic [AW-1:0] mem_addr;
    logic          mem_re;
    logic          mem_we;

    state_t state_reg, state_next;

    logic               bad_reg;
    logic               query_reg;
    logic [7:0]         code_reg;
    logic [7:0]         first_reg;
    logic [7:0]         lo_reg;
    logic [7:0]         dx_reg;
    logic [AW-1:0]      ptr_reg;
    logic [PW-1:0]      n_reg;
    logic [PW-1:0]      i_reg;
    logic signed [15:0] ox_reg;
    logic signed [15:0] oy_reg;
    logic [7:0]         fin_adv_reg;
    logic [1:0]         fin_status_reg;

    logic               out_valid_reg;
    logic signed [16:0] out_x_reg;
    logic signed [16:0] out_y_reg;
    logic [23:0]        out_color_reg;
    logic [7:0]         out_adv_reg;
    logic [1:0]         out_status_reg;
    logic               out_last_reg;

    logic               out_free;
    logic               out_of_range;
    logic signed [17:0] diff_s;
    logic signed [17:0] tbl_s;
    logic [AW-1:0]      tbl_addr;
    logic [15:0]        word16;
    logic [AW-1:0]      off_addr;
    logic               trunc;
    logic [PW-1:0]      n_calc;
    logic signed [16:0] px;
    logic signed [16:0] py;
    logic               in_view;
    logic               keep;
    logic               last_pix;
    logic               pix_emit;
    logic               fin_emit;

    assign out_free     = !out_valid_reg || m_ready;
    assign out_of_range = (code_reg < first_reg) || (code_reg > rdata_reg);

    // offset table slot: font_size - 2*(last - first + 1) + 2*(code - first)
    assign diff_s   = $signed({10'd0, code_reg}) - $signed({10'd0, rdata_reg}) - 18'sd1;
    assign tbl_s    = $signed({5'd0, cfg.font_size}) + (diff_s <<< 1);
    assign tbl_addr = tbl_s[AW-1:0];

    // little-endian pair: low byte held, high byte just read
    assign word16   = {rdata_reg, lo_reg};
    assign off_addr = word16[AW-1:0];
    assign trunc    = word16 > 16'(MAX_GLYPH_PIXELS);
    assign n_calc   = trunc ? PW'(MAX_GLYPH_PIXELS) : word16[PW-1:0];

    assign px = $signed({ox_reg[15], ox_reg}) + $signed({9'd0, dx_reg});
    assign py = $signed({oy_reg[15], oy_reg}) + $signed({9'd0, rdata_reg});
    assign in_view = ($signed({cfg.clip_left[15], cfg.clip_left}) <= px)
                  && (px <= $signed({cfg.clip_right[15], cfg.clip_right}))
                  && ($signed({cfg.clip_top[15], cfg.clip_top}) <= py)
                  && (py <= $signed({cfg.clip_bottom[15], cfg.clip_bottom}));
    assign keep     = !cfg.clip_enable || in_view;
    assign last_pix = (i_reg + PW'(1)) == n_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid && q_cmd.op != OP_WRITE) begin
                    state_next = ST_MAG0;
                end
            end
            ST_MAG0:  state_next = ST_MAG1;
            ST_MAG1:  state_next = ST_MAG2;
            ST_MAG2:  state_next = ST_MAG3;
            ST_MAG3:  state_next = ST_FIRST;
            ST_FIRST: state_next = ST_LAST;
            ST_LAST: begin
                if (bad_reg || out_of_range) begin
                    state_next = ST_FINAL;
                end else begin
                    state_next = ST_TBL0;
                end
            end
            ST_TBL0:  state_next = ST_TBL1;
            ST_TBL1:  state_next = ST_WIDTH;
            ST_WIDTH: state_next = query_reg ? ST_FINAL : ST_CNT0;
            ST_CNT0:  state_next = ST_CNT1;
            ST_CNT1:  state_next = (word16 == 16'd0) ? ST_FINAL : ST_PIX_X;
            ST_PIX_X: state_next = ST_PIX_Y;
            ST_PIX_Y: begin
                if (!(keep && !out_free)) begin
                    state_next = last_pix ? ST_FINAL : ST_PIX_X;
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        mem_addr = '0;
        mem_re   = 1'b0;
        mem_we   = 1'b0;
        q_pop    = 1'b0;
        pix_emit = 1'b0;
        fin_emit = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    if (q_cmd.op == OP_WRITE) begin
                        mem_we   = 1'b1;
                        mem_addr = AW'(q_cmd.addr);
                    end else begin
                        mem_re   = 1'b1;
                        mem_addr = '0;
                    end
                end
            end
            ST_MAG0: begin
                mem_re   = 1'b1;
                mem_addr = AW'(1);
            end
            ST_MAG1: begin
                mem_re   = 1'b1;
                mem_addr = AW'(2);
            end
            ST_MAG2: begin
                mem_re   = 1'b1;
                mem_addr = AW'(3);
            end
            ST_MAG3: begin
                mem_re   = 1'b1;
                mem_addr = AW'(HDR_FIRST);
            end
            ST_FIRST: begin
                mem_re   = 1'b1;
                mem_addr = AW'(HDR_LAST);
            end
            ST_LAST: begin
                if (!(bad_reg || out_of_range)) begin
                    mem_re   = 1'b1;
                    mem_addr = tbl_addr;
                end
            end
            ST_TBL0: begin
                mem_re   = 1'b1;
                mem_addr = ptr_reg + AW'(1);
            end
            ST_TBL1: begin
                mem_re   = 1'b1;
                mem_addr = off_addr;
            end
            ST_WIDTH: begin
                if (!query_reg) begin
                    mem_re   = 1'b1;
                    mem_addr = ptr_reg + AW'(1);
                end
            end
            ST_CNT0: begin
                mem_re   = 1'b1;
                mem_addr = ptr_reg + AW'(2);
            end
            ST_CNT1: begin
                if (word16 != 16'd0) begin
                    mem_re   = 1'b1;
                    mem_addr = ptr_reg + AW'(3);
                end
            end
            ST_PIX_X: begin
                mem_re   = 1'b1;
                mem_addr = ptr_reg + AW'(1);
            end
            ST_PIX_Y: begin
                if (!(keep && !out_free)) begin
                    pix_emit = keep;
                    if (!last_pix) begin
                        mem_re   = 1'b1;
                        mem_addr = ptr_reg + AW'(2);
                    end
                end
            end
            ST_FINAL: begin
                fin_emit = out_free;
            end
            default: begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= q_cmd.wbyte;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // sequencer datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (q_valid && q_cmd.op != OP_WRITE) begin
                    bad_reg   <= 1'b0;
                    query_reg <= (q_cmd.op == OP_QUERY);
                    code_reg  <= q_cmd.code;
                    ox_reg    <= q_cmd.ox;
                    oy_reg    <= q_cmd.oy;
                end
            end
            ST_MAG0:  bad_reg <= bad_reg | (rdata_reg != FONT_MAGIC[7:0]);
            ST_MAG1:  bad_reg <= bad_reg | (rdata_reg != FONT_MAGIC[15:8]);
            ST_MAG2:  bad_reg <= bad_reg | (rdata_reg != FONT_MAGIC[23:16]);
            ST_MAG3:  bad_reg <= bad_reg | (rdata_reg != FONT_MAGIC[31:24]);
            ST_FIRST: first_reg <= rdata_reg;
            ST_LAST: begin
                ptr_reg <= tbl_addr;
                if (bad_reg) begin
                    fin_adv_reg    <= 8'd0;
                    fin_status_reg <= STAT_BAD_MAGIC;
                end else if (out_of_range) begin
                    fin_adv_reg    <= cfg.space_len;
                    fin_status_reg <= STAT_NO_CODE;
                end
            end
            ST_TBL0:  lo_reg <= rdata_reg;
            ST_TBL1:  ptr_reg <= off_addr;
            ST_WIDTH: begin
                fin_adv_reg    <= rdata_reg;
                fin_status_reg <= STAT_OK;
            end
            ST_CNT0:  lo_reg <= rdata_reg;
            ST_CNT1: begin
                n_reg          <= n_calc;
                i_reg          <= '0;
                ptr_reg        <= ptr_reg + AW'(3);
                fin_status_reg <= trunc ? STAT_TRUNC : STAT_OK;
            end
            ST_PIX_X: dx_reg <= rdata_reg;
            ST_PIX_Y: begin
                if (!(keep && !out_free)) begin
                    i_reg   <= i_reg + PW'(1);
                    ptr_reg <= ptr_reg + AW'(2);
                end
            end
            default: begin
                lo_reg <= lo_reg;
            end
        endcase
    end

    // result word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pix_emit || fin_emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_emit) begin
            out_x_reg      <= px;
            out_y_reg      <= py;
            out_color_reg  <= cfg.draw_color;
            out_adv_reg    <= 8'd0;
            out_status_reg <= STAT_OK;
            out_last_reg   <= 1'b0;
        end else if (fin_emit) begin
            out_x_reg      <= '0;
            out_y_reg      <= '0;
            out_color_reg  <= '0;
            out_adv_reg    <= fin_adv_reg;
            out_status_reg <= fin_status_reg;
            out_last_reg   <= 1'b1;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_pixel_x     = out_x_reg;
    assign m_pixel_y     = out_y_reg;
    assign m_pixel_color = out_color_reg;
    assign m_advance     = out_adv_reg;
    assign m_status      = out_status_reg;
    assign m_last        = out_last_reg;

endmodule
